### src/pfra_pkg.sv
`default_nettype none

package pfra_pkg;

  localparam int OP_W     = 1;
  localparam int START_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int FC_W     = 13;
  localparam int ADDR_W   = 24;

  localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [START_W-1:0] start_frame;
    logic [COUNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic mark;
    logic free;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_free;
    logic req_zero;
    logic found;
    logic scan_end;
    logic mark_last;
    logic free_end;
  } status_t;

endpackage

`default_nettype wire

### src/pfra_datapath.sv
`default_nettype none

module pfra_datapath
  import pfra_pkg::*;
#(
  parameter int MAX_FRAMES = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  req_t            request,
  input  cmd_t            cmd,
  input  logic            cfg_wr,
  input  logic [FC_W-1:0] cfg_data,
  output status_t         status,
  output rsp_t            result
);

  localparam int FW = $clog2(MAX_FRAMES);
  // Wide enough for the frame count itself and for start plus count on a free.
  localparam int CW = (FW + 1 > 14) ? FW + 1 : 14;
  localparam logic [CW-1:0]     MAX_C  = CW'(MAX_FRAMES);
  localparam logic [FW-1:0]     LAST_F = FW'(MAX_FRAMES - 1);
  localparam logic [ADDR_W-1:0] PB     = ADDR_W'(PAGE_BYTES);

  logic              mem [MAX_FRAMES];
  logic              mem_q;

  logic [FC_W-1:0]   frame_count;
  logic [CW-1:0]     hint;
  logic [CW-1:0]     scan_idx;
  logic [CW-1:0]     chk_idx;
  logic              chk_vld;
  logic [CW-1:0]     run;
  logic [CW-1:0]     count;
  logic [CW-1:0]     run_first;
  logic [CW-1:0]     run_last;
  logic [CW-1:0]     mark_idx;
  logic [CW-1:0]     free_idx;
  logic [CW-1:0]     free_left;
  logic [FW-1:0]     clr_idx;
  logic              res_found;
  logic [ADDR_W-1:0] res_addr;

  logic [CW-1:0]     fc_ext;
  logic [CW-1:0]     fc_eff;
  logic [CW-1:0]     run_inc;
  logic [CW-1:0]     hit_first;
  logic [CW-1:0]     start_ext;
  logic              hit;
  logic              issue;
  logic              free_end;

  always_comb begin
    fc_ext    = CW'(frame_count);
    fc_eff    = (fc_ext > MAX_C) ? MAX_C : fc_ext;
    run_inc   = run + CW'(1);
    hit_first = chk_idx + CW'(1) - count;
    start_ext = CW'(request.start_frame);
    hit       = chk_vld && !mem_q && (run_inc == count);
    issue     = cmd.scan && (scan_idx < fc_eff);
    free_end  = (free_left == '0) || (free_idx >= fc_eff);
  end

  always_comb begin
    status.clear_last = (clr_idx == LAST_F);
    status.req_free   = (request.op == OP_FREE);
    status.req_zero   = (request.page_count == '0);
    status.found      = hit;
    // The scan is over once the last issued read has been checked.
    status.scan_end   = !chk_vld && (scan_idx >= fc_eff);
    status.mark_last  = (mark_idx == run_last);
    status.free_end   = free_end;
  end

  assign result.found   = res_found;
  assign result.address = res_addr;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_idx] <= 1'b0;
    end else if (cmd.mark) begin
      mem[mark_idx[FW-1:0]] <= 1'b1;
    end else if (cmd.free && !free_end) begin
      mem[free_idx[FW-1:0]] <= 1'b0;
    end
    mem_q <= mem[scan_idx[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      hint        <= '0;
      chk_vld     <= 1'b0;
      clr_idx     <= '0;
    end else begin
      if (cfg_wr) begin
        frame_count <= cfg_data;
      end
      if (cmd.clear) begin
        clr_idx <= clr_idx + FW'(1);
      end
      if (cmd.load) begin
        chk_vld <= 1'b0;
        if (request.op == OP_FREE && start_ext < hint) begin
          hint <= start_ext;
        end
      end else begin
        chk_vld <= issue;
      end
      if (cmd.mark && mark_idx == run_last) begin
        hint <= run_last + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx  <= hint;
      run       <= '0;
      count     <= CW'(request.page_count);
      free_idx  <= start_ext;
      free_left <= CW'(request.page_count);
      res_found <= (request.op == OP_FREE);
      res_addr  <= '0;
    end else begin
      if (issue) begin
        scan_idx <= scan_idx + CW'(1);
        chk_idx  <= scan_idx;
      end
      if (cmd.scan && chk_vld) begin
        run <= mem_q ? '0 : run_inc;
      end
      if (cmd.scan && hit) begin
        run_first <= hit_first;
        run_last  <= chk_idx;
        mark_idx  <= hit_first;
      end
      if (cmd.mark) begin
        mark_idx  <= mark_idx + CW'(1);
        res_found <= 1'b1;
        res_addr  <= ADDR_W'(run_first) * PB;
      end
      if (cmd.free && !free_end) begin
        free_idx  <= free_idx + CW'(1);
        free_left <= free_left - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/pfra_ctrl.sv
`default_nettype none

module pfra_ctrl
  import pfra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          priority if (status.req_free) state_next = ST_FREE;
          else if (status.req_zero)     state_next = ST_DONE;
          else                          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status.found) state_next = ST_MARK;
        else if (status.scan_end)  state_next = ST_DONE;
      end
      ST_MARK: begin
        if (status.mark_last) state_next = ST_DONE;
      end
      ST_FREE: begin
        if (status.free_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd.clear = (state == ST_CLEAR);
    cmd.load  = (state == ST_IDLE) && start;
    cmd.scan  = (state == ST_SCAN);
    cmd.mark  = (state == ST_MARK);
    cmd.free  = (state == ST_FREE);
    busy      = (state != ST_IDLE);
    done      = (state == ST_DONE);
  end

endmodule

`default_nettype wire

### src/page_frame_run_allocator.sv
// First-fit allocator for runs of physical frames, one used bit per frame.
// A request (op, start_frame, page_count) is taken when start is high and
// busy is low. Exactly one result follows: done is high for one cycle with
// result.found and result.address valid in that cycle. The receiver cannot
// stall; the result is taken in that cycle.
// An allocate scans the frame map one frame per cycle from the next-free
// hint, then marks the run used one frame per cycle. Its result follows
// the scan and the marking of the run, or the scan alone when no run is
// found. A zero-length allocate answers without a scan. A free clears one
// frame per cycle, up to page_count frames or the frames left below
// frame_count, and then answers. busy drops the cycle after done, so a new
// request can be taken in that cycle.
// The frame_count register is written over cfg_valid/cfg_ready, ready always
// high, and should be written only while the block is idle.
// After reset the block sweeps the frame map clear, one frame per cycle;
// busy stays high during the sweep.
`default_nettype none

module page_frame_run_allocator
  import pfra_pkg::*;
#(
  parameter int MAX_FRAMES = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  req_t            request,
  output logic            done,
  output rsp_t            result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [FC_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pfra_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pfra_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .cfg_wr   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .result   (result)
  );

endmodule

`default_nettype wire

### verif/page_frame_run_allocator_tb.sv
`timescale 1ns / 1ps

module page_frame_run_allocator_tb;
  import pfra_pkg::*;

  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_BYTES = 4096;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  req_t            request = '0;
  logic            done;
  rsp_t            result;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [FC_W-1:0] cfg_data = '0;

  page_frame_run_allocator #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the frame map, the hint and the frame_count register.
  bit              frame_taken [MAX_FRAMES];
  logic [FC_W-1:0] hint_frame = '0;
  logic [FC_W-1:0] frame_limit = FRAME_COUNT_RESET;

  req_t pending_requests[$];
  rsp_t expected_results[$];

  int issued_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int sender_idle_pct = 19;
  int runs_granted = 0;
  int runs_refused = 0;
  int frees_done = 0;
  int limit_writes = 0;

  function automatic rsp_t predict_frames(req_t r);
    rsp_t rsp;
    int   fc;
    int   run_len;
    int   first;
    int   i;
    int   k;
    rsp = '0;
    fc = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    if (r.op == OP_ALLOC) begin
      if (r.page_count != 0) begin
        run_len = 0;
        i = hint_frame;
        while (!rsp.found && i < fc) begin
          if (frame_taken[i]) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == r.page_count) begin
              first = i + 1 - int'(r.page_count);
              for (k = first; k <= i; k++) frame_taken[k] = 1'b1;
              hint_frame = FC_W'(i + 1);
              rsp.found = 1'b1;
              rsp.address = ADDR_W'(longint'(first) * PAGE_BYTES);
            end
          end
          i++;
        end
      end
      if (rsp.found) runs_granted++;
      else runs_refused++;
    end else begin
      i = 0;
      while (i < r.page_count && int'(r.start_frame) + i < fc) begin
        frame_taken[int'(r.start_frame) + i] = 1'b0;
        i++;
      end
      if (r.start_frame < hint_frame) hint_frame = FC_W'(r.start_frame);
      rsp.found = 1'b1;
      frees_done++;
    end
    return rsp;
  endfunction

  // A new request goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (accepted_count == issued_count) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        request <= pending_requests.pop_front();
        start <= 1'b1;
        issued_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got found=%0b address=%h",
                   $time, result.found, result.address);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, result.found);
            error_count++;
          end
          if (result.address !== want.address) begin
            $display("%0t: address mismatch, expected %h, got %h",
                     $time, want.address, result.address);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_frames(request));
        accepted_count++;
      end
    end
  end

  task automatic queue_request(logic [OP_W-1:0] op, int first_frame, int count);
    req_t r;
    r.op = op;
    r.start_frame = START_W'(first_frame);
    r.page_count = COUNT_W'(count);
    pending_requests.push_back(r);
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (!(pending_requests.size() == 0 && issued_count == accepted_count &&
             expected_results.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_count(int value);
    wait_until_idle();
    cfg_valid <= 1'b1;
    cfg_data <= FC_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    frame_limit = FC_W'(value);
    limit_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly allocate/free traffic sized to the managed frames, with some
  // zero-length and full-width requests mixed in.
  task automatic queue_random_requests(int n, int fc);
    int pick;
    int span;
    span = (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_request(OP_ALLOC, $urandom_range(4095),
                      $urandom_range(1, (span < 4) ? 1 : span / 4));
      end else if (pick < 85) begin
        queue_request(OP_FREE, $urandom_range(span - 1),
                      $urandom_range(1, (span < 2) ? 1 : span / 2));
      end else if (pick < 90) begin
        queue_request(OP_ALLOC, $urandom_range(4095), 0);
      end else if (pick < 95) begin
        queue_request(OP_ALLOC, $urandom_range(4095), $urandom_range(8191));
      end else begin
        queue_request(OP_FREE, $urandom_range(4095), $urandom_range(8191));
      end
    end
  endtask

  initial begin
    int limits [10];
    int counts [10];
    limits = '{16, 1, 4096, 64, 37, 8191, 3, 200, 8, 4096};
    counts = '{14, 14, 6, 14, 14, 6, 14, 14, 14, 6};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole map, then leave a free frame below the hint so that
    // the search has to refuse rather than wrap around.
    queue_request(OP_ALLOC, 4095, 0);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_ALLOC, 0, 4095);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 4095, 1);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 0, 0);
    queue_request(OP_FREE, 100, 2);
    queue_request(OP_FREE, 50, 1);
    queue_request(OP_ALLOC, 0, 2);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 4000, 8191);

    // With no frames managed every allocate fails and frees touch nothing.
    write_frame_count(0);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_FREE, 5, 3);

    write_frame_count(8191);
    queue_request(OP_ALLOC, 0, 96);
    queue_request(OP_ALLOC, 0, 1);

    write_frame_count(16);
    queue_request(OP_FREE, 0, 8191);
    queue_request(OP_FREE, 4095, 1);
    queue_request(OP_ALLOC, 0, 16);
    queue_request(OP_ALLOC, 0, 17);

    for (int p = 0; p < 10; p++) begin
      write_frame_count(limits[p]);
      sender_idle_pct = (p < 3) ? 19 : (p < 7) ? 86 : 0;
      queue_random_requests(counts[p], limits[p]);
    end

    wait_until_idle();
    repeat (16) @(posedge clk);
    $display("Ran %0d requests: %0d runs granted, %0d refused, %0d frees,",
             accepted_count, runs_granted, runs_refused, frees_done);
    $display("across %0d frame_count writes from 0 to 8191.", limit_writes);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out waiting for the allocator.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
